FILE: src/cdq_pkg.sv
// Shared types and constants for the circular double-ended queue.
// Used by cdq_ctrl, cdq_store, the top level and the checker; no dependencies.
package cdq_pkg;

  localparam int DEPTH_DEFAULT     = 1024;
  localparam int WORD_BITS_DEFAULT = 32;

  // Fixed port widths of the item fields.
  localparam int OP_W     = 3;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 10;
  localparam int COUNT_W  = 11;
  localparam int STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_READ       = 3'd4,
    OP_CLEAR      = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Result fields that the control logic settles at acceptance time and
  // that travel alongside the store read until the output register.
  typedef struct packed {
    logic                has_value;
    logic [COUNT_W-1:0]  count;
    logic                empty;
    status_t             status;
  } result_info_t;

endpackage

FILE: src/circular_double_ended_queue.sv
// Top level of the circular double-ended queue: handshake, store and output register.
// Depends on cdq_pkg, cdq_ctrl and cdq_store.
//
// Usage: each input item (operation, data_value, position) asks for one of push back,
// push front, pop front, pop back, read at an offset from the front, or clear, and
// produces exactly one result item (read_value, element_count, is_empty, status).
// Both channels use valid and stall; an item moves on an edge where valid is high
// and stall is low.
// The store read and the result fields are registered at the edge that accepts the item,
// and the output register loads from them as soon as it is free to take a new result.
// Throughput is one item per cycle while the receiver does not stall. Every item
// touches at most one store entry, and pointers and count are settled at acceptance,
// so back-to-back items need no forwarding: a write lands before the next item's read.
// When the receiver stalls, the output register holds its result and one more
// item may still enter the store-read stage; after that in_stall rises.
// Reset (synchronous, active high) empties the queue and drops any item in flight;
// the store contents are not cleared, since no occupied slot is ever unwritten.
module circular_double_ended_queue #(
  parameter int DEPTH     = cdq_pkg::DEPTH_DEFAULT,
  parameter int WORD_BITS = cdq_pkg::WORD_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cdq_pkg::OP_W-1:0]      operation,
  input  logic [cdq_pkg::DATA_W-1:0]    data_value,
  input  logic [cdq_pkg::POS_W-1:0]     position,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cdq_pkg::DATA_W-1:0]    read_value,
  output logic [cdq_pkg::COUNT_W-1:0]   element_count,
  output logic                          is_empty,
  output logic [cdq_pkg::STATUS_W-1:0]  status
);

  localparam int PW = $clog2(DEPTH);

  logic                  accept;
  logic                  mem_we, mem_re;
  logic [PW-1:0]         mem_addr;
  logic [WORD_BITS-1:0]  mem_rdata;
  cdq_pkg::result_info_t s1_info;
  logic                  s1_valid;
  logic                  s1_advance;

  // The read stage may only take a new item if it can pass its current one on.
  assign in_stall   = s1_valid & out_valid & out_stall;
  assign accept     = in_valid & ~in_stall;
  assign s1_advance = s1_valid & (~out_valid | ~out_stall);

  cdq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .operation (operation),
    .position  (position),
    .mem_we    (mem_we),
    .mem_re    (mem_re),
    .mem_addr  (mem_addr),
    .info      (s1_info)
  );

  cdq_store #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (WORD_BITS'(data_value)),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= accept | (s1_valid & ~s1_advance);
      out_valid <= s1_advance | (out_valid & out_stall);
    end
  end

  // Pushes, clears and refused operations report a zero word.
  always_ff @(posedge clk) begin
    if (s1_advance) begin
      read_value    <= s1_info.has_value ? cdq_pkg::DATA_W'(mem_rdata) : '0;
      element_count <= s1_info.count;
      is_empty      <= s1_info.empty;
      status        <= s1_info.status;
    end
  end

endmodule

FILE: src/cdq_store.sv
// Element store of the deque: one synchronous memory, one access per cycle.
// Depends on cdq_pkg for the default sizes.
module cdq_store #(
  parameter int DEPTH     = cdq_pkg::DEPTH_DEFAULT,
  parameter int WORD_BITS = cdq_pkg::WORD_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic                         re,
  input  logic [$clog2(DEPTH)-1:0]     addr,
  input  logic [WORD_BITS-1:0]         wdata,
  output logic [WORD_BITS-1:0]         rdata
);

  logic [WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

FILE: src/cdq_ctrl.sv
// Pointer, occupancy and status logic of the deque; drives the store port.
// Depends on cdq_pkg.
module cdq_ctrl #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [cdq_pkg::OP_W-1:0]      operation,
  input  logic [cdq_pkg::POS_W-1:0]     position,
  output logic                          mem_we,
  output logic                          mem_re,
  output logic [$clog2(DEPTH)-1:0]      mem_addr,
  output cdq_pkg::result_info_t         info
);

  localparam int PW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > cdq_pkg::POS_W) ? CW : cdq_pkg::POS_W;
  localparam int SW   = ((PW > cdq_pkg::POS_W) ? PW : cdq_pkg::POS_W) + 1;

  logic [PW-1:0] head, head_next, tail, tail_next;
  logic [CW-1:0] occ, occ_next;
  logic [PW-1:0] head_up, head_dn, tail_up, tail_dn;
  logic [SW-1:0] pos_sum, pos_wrap;
  logic          full, empty, pos_out;
  logic          we, re, has_value;
  cdq_pkg::status_t     st;
  cdq_pkg::result_info_t info_next;

  assign full    = (occ == CW'(DEPTH));
  assign empty   = (occ == '0);
  assign head_up = (head == PW'(DEPTH - 1)) ? '0 : head + PW'(1);
  assign head_dn = (head == '0) ? PW'(DEPTH - 1) : head - PW'(1);
  assign tail_up = (tail == PW'(DEPTH - 1)) ? '0 : tail + PW'(1);
  assign tail_dn = (tail == '0) ? PW'(DEPTH - 1) : tail - PW'(1);

  // A valid read offset is below the count, so the sum stays under twice the depth.
  assign pos_sum  = SW'(head) + SW'(position);
  assign pos_wrap = (pos_sum >= SW'(DEPTH)) ? pos_sum - SW'(DEPTH) : pos_sum;
  assign pos_out  = (CMPW'(position) >= CMPW'(occ));

  always_comb begin
    head_next = head;
    tail_next = tail;
    occ_next  = occ;
    we        = 1'b0;
    re        = 1'b0;
    has_value = 1'b0;
    mem_addr  = head;
    st        = cdq_pkg::ST_OK;
    unique case (cdq_pkg::op_t'(operation))
      cdq_pkg::OP_PUSH_BACK: begin
        if (full) begin
          st = cdq_pkg::ST_FULL;
        end else begin
          we        = 1'b1;
          mem_addr  = tail;
          tail_next = tail_up;
          occ_next  = occ + CW'(1);
        end
      end
      cdq_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          st = cdq_pkg::ST_FULL;
        end else begin
          we        = 1'b1;
          mem_addr  = head_dn;
          head_next = head_dn;
          occ_next  = occ + CW'(1);
        end
      end
      cdq_pkg::OP_POP_FRONT: begin
        if (empty) begin
          st = cdq_pkg::ST_EMPTY;
        end else begin
          re        = 1'b1;
          has_value = 1'b1;
          mem_addr  = head;
          head_next = head_up;
          occ_next  = occ - CW'(1);
        end
      end
      cdq_pkg::OP_POP_BACK: begin
        if (empty) begin
          st = cdq_pkg::ST_EMPTY;
        end else begin
          re        = 1'b1;
          has_value = 1'b1;
          mem_addr  = tail_dn;
          tail_next = tail_dn;
          occ_next  = occ - CW'(1);
        end
      end
      cdq_pkg::OP_READ: begin
        if (pos_out) begin
          st = cdq_pkg::ST_RANGE;
        end else begin
          re        = 1'b1;
          has_value = 1'b1;
          mem_addr  = PW'(pos_wrap);
        end
      end
      cdq_pkg::OP_CLEAR: begin
        head_next = '0;
        tail_next = '0;
        occ_next  = '0;
      end
      default: begin
        // Unused operation codes leave everything as it is.
      end
    endcase
  end

  assign info_next.has_value = has_value;
  assign info_next.count     = cdq_pkg::COUNT_W'(occ_next);
  assign info_next.empty     = (occ_next == '0);
  assign info_next.status    = st;

  assign mem_we = accept & we;
  assign mem_re = accept & re;

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      occ  <= '0;
    end else if (accept) begin
      head <= head_next;
      tail <= tail_next;
      occ  <= occ_next;
    end
  end

  // Aligned with the store's registered read data.
  always_ff @(posedge clk) begin
    if (accept) begin
      info <= info_next;
    end
  end

endmodule

FILE: src/cdq_checker.sv
// Port-level checker for the circular double-ended queue, bound to the top level.
// Depends on cdq_pkg and circular_double_ended_queue.
module cdq_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [cdq_pkg::DATA_W-1:0]    read_value,
  input logic [cdq_pkg::COUNT_W-1:0]   element_count,
  input logic                          is_empty,
  input logic [cdq_pkg::STATUS_W-1:0]  status
);

  // A stalled result stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_value)
      && $stable(element_count) && $stable(status))
    else $error("result changed while stalled");

  // An empty queue always reports a zero count.
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_empty |-> element_count == '0)
    else $error("empty flag with nonzero count");

  // Refused operations carry no element.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != cdq_pkg::ST_OK |-> read_value == '0)
    else $error("refused operation returned a value");

  // A refused pop means the queue is empty, a refused push that it is not.
  a_status_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == cdq_pkg::ST_EMPTY || status == cdq_pkg::ST_FULL)
      |-> is_empty == (status == cdq_pkg::ST_EMPTY))
    else $error("status disagrees with empty flag");

  // Reset drops any result in flight.
  a_reset_flush: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind circular_double_ended_queue cdq_checker u_checker (.*);
